// ===== sv/pea_pkg.sv =====
// Shared types and constants for the page extent allocator.
// Depends on nothing; every other file imports it.
package pea_pkg;

    localparam int MAX_EXTENTS_DEF      = 64;
    localparam int PAGE_NUMBER_BITS_DEF = 36;
    localparam int FIELD_BITS           = 36;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_ALLOC = 2'd1,
        OP_FREE  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_NOFIT = 2'd1,
        ST_FULL  = 2'd2,
        ST_ZERO  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DROP,
        S_INS,
        S_DONE
    } t_state;

endpackage

// ===== sv/pea_table.sv =====
// Extent table storage: one write port, one read port, registered read.
// Depends on pea_pkg.
module pea_table
    import pea_pkg::*;
#(
    parameter int DEPTH = MAX_EXTENTS_DEF,
    parameter int DW    = 2 * PAGE_NUMBER_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DW-1:0]            i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DW-1:0]            o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/page_extent_allocator_top.sv =====
// Page extent allocator: first-fit free list of page extents with coalescing.
// Sequence: add, zero-length and unused codes go from idle straight to the done state,
//   which loads the result register when the output is free; allocate and free examine
//   table slots in the scan state, then shift entries in the drop or insert state as needed.
// Throughput: one item in work at a time; the next beat is taken in the cycle after the
//   result loads. The walk and shift run one entry per cycle through pea_table.
// Reset: synchronous, active low; clears control, entry count and free total.
//   Table contents are not cleared, only entries below the count are read.
module page_extent_allocator_top
    import pea_pkg::*;
#(
    parameter int MAX_EXTENTS      = MAX_EXTENTS_DEF,
    parameter int PAGE_NUMBER_BITS = PAGE_NUMBER_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [1:0]            i_operation,
    input  logic [FIELD_BITS-1:0] i_base_page,
    input  logic [FIELD_BITS-1:0] i_run_pages,
    input  logic                  i_usable,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [1:0]            o_status,
    output logic [FIELD_BITS-1:0] o_result_page,
    output logic [FIELD_BITS-1:0] o_free_total
);

    localparam int PNB = PAGE_NUMBER_BITS;
    localparam int IW  = $clog2(MAX_EXTENTS);
    localparam int CW  = $clog2(MAX_EXTENTS + 1);

    // control
    t_state          r_state, n_state;
    t_op             r_op, n_op;
    logic [CW-1:0]   r_idx, n_idx;
    logic [CW-1:0]   r_count, n_count;
    // item and working payload
    logic [PNB-1:0]  r_b, n_b;
    logic [PNB-1:0]  r_n, n_n;
    logic [PNB-1:0]  r_prev_b, n_prev_b;
    logic [PNB-1:0]  r_prev_l, n_prev_l;
    logic [2*PNB-1:0] r_carry, n_carry;
    logic [PNB-1:0]  r_free, n_free;
    t_status         r_st, n_st;
    logic [PNB-1:0]  r_page, n_page;
    // result register
    logic            r_ov;
    t_status         r_o_st;
    logic [PNB-1:0]  r_o_page;
    logic [PNB-1:0]  r_o_free;

    // table port
    logic             we;
    logic [IW-1:0]    waddr, raddr;
    logic [2*PNB-1:0] wdata, rdata;

    pea_table #(
        .DEPTH (MAX_EXTENTS),
        .DW    (2 * PNB)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // input beat decode
    t_op            in_op;
    logic [PNB-1:0] in_b, in_n;
    logic           in_acc, in_zero, out_free, table_full;

    assign in_op      = t_op'(i_operation);
    assign in_b       = PNB'(i_base_page);
    assign in_n       = PNB'(i_run_pages);
    assign in_zero    = (in_n == '0);
    assign in_acc     = i_in_valid && (r_state == S_IDLE);
    assign out_free   = !r_ov || !i_out_stall;
    assign table_full = (r_count == CW'(MAX_EXTENTS));

    // walk decisions on the entry in rdata (index r_idx)
    logic [PNB-1:0] cur_b, cur_l;
    logic           cur_ok, fit, exact, above, lo, hi;
    logic [CW:0]    idx_p1;
    logic [CW-1:0]  idx_m1;

    assign cur_b  = rdata[2*PNB-1:PNB];
    assign cur_l  = rdata[PNB-1:0];
    assign cur_ok = (r_idx < r_count);
    assign fit    = cur_ok && (cur_l >= r_n);
    assign exact  = (cur_l == r_n);
    assign above  = !cur_ok || (cur_b > r_b);
    assign lo     = (r_idx != '0) &&
                    (({1'b0, r_prev_b} + {1'b0, r_prev_l}) == {1'b0, r_b});
    assign hi     = cur_ok && (({1'b0, r_b} + {1'b0, r_n}) == {1'b0, cur_b});
    assign idx_p1 = {1'b0, r_idx} + (CW+1)'(1);
    assign idx_m1 = r_idx - CW'(1);

    // read one entry ahead; the shift-down reads two ahead of its write
    always_comb begin
        unique case (r_state)
            S_IDLE:  raddr = '0;
            S_DROP:  raddr = IW'(r_idx + CW'(2));
            default: raddr = IW'(r_idx + CW'(1));
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if ((in_op == OP_ALLOC || in_op == OP_FREE) && !in_zero) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SCAN: begin
                if (r_op == OP_ALLOC) begin
                    priority if (!cur_ok)   n_state = S_DONE;
                    else if (fit && exact)  n_state = S_DROP;
                    else if (fit)           n_state = S_DONE;
                    else                    n_state = S_SCAN;
                end else if (above) begin
                    priority if (lo && hi)  n_state = S_DROP;
                    else if (lo || hi)      n_state = S_DONE;
                    else if (table_full)    n_state = S_DONE;
                    else if (cur_ok)        n_state = S_INS;
                    else                    n_state = S_DONE;
                end
            end
            S_DROP:  if (idx_p1 >= {1'b0, r_count}) n_state = S_DONE;
            S_INS:   if (r_idx == r_count) n_state = S_DONE;
            S_DONE:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and table writes
    always_comb begin
        n_op     = r_op;
        n_idx    = r_idx;
        n_count  = r_count;
        n_b      = r_b;
        n_n      = r_n;
        n_prev_b = r_prev_b;
        n_prev_l = r_prev_l;
        n_carry  = r_carry;
        n_free   = r_free;
        n_st     = r_st;
        n_page   = r_page;
        we       = 1'b0;
        waddr    = r_idx[IW-1:0];
        wdata    = {r_b, r_n};
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_op   = in_op;
                    n_b    = in_b;
                    n_n    = in_n;
                    n_idx  = '0;
                    n_page = '0;
                    n_st   = ST_OK;
                    unique case (in_op)
                        OP_ADD: begin
                            if (i_usable) begin
                                priority if (in_zero) n_st = ST_ZERO;
                                else if (table_full)  n_st = ST_FULL;
                                else begin
                                    // append at the end of the table
                                    we      = 1'b1;
                                    waddr   = r_count[IW-1:0];
                                    wdata   = {in_b, in_n};
                                    n_count = r_count + CW'(1);
                                    n_free  = r_free + in_n;
                                end
                            end
                        end
                        OP_ALLOC, OP_FREE: if (in_zero) n_st = ST_ZERO;
                        OP_NONE: ;
                        default: ;
                    endcase
                end
            end
            S_SCAN: begin
                if (r_op == OP_ALLOC) begin
                    priority if (!cur_ok) n_st = ST_NOFIT;
                    else if (fit) begin
                        n_page = cur_b;
                        n_free = r_free - r_n;
                        if (!exact) begin
                            // trim the run from the front of the extent
                            we    = 1'b1;
                            wdata = {cur_b + r_n, cur_l - r_n};
                        end
                    end else begin
                        n_idx = idx_p1[CW-1:0];
                    end
                end else if (above) begin
                    priority if (lo && hi) begin
                        // fold run and upper neighbor into the lower one
                        we     = 1'b1;
                        waddr  = idx_m1[IW-1:0];
                        wdata  = {r_prev_b, r_prev_l + r_n + cur_l};
                        n_free = r_free + r_n;
                    end else if (lo) begin
                        we     = 1'b1;
                        waddr  = idx_m1[IW-1:0];
                        wdata  = {r_prev_b, r_prev_l + r_n};
                        n_free = r_free + r_n;
                    end else if (hi) begin
                        we     = 1'b1;
                        wdata  = {r_b, cur_l + r_n};
                        n_free = r_free + r_n;
                    end else if (table_full) begin
                        n_st = ST_FULL;
                    end else begin
                        // place the run here, carry the old entry upward
                        we     = 1'b1;
                        wdata  = {r_b, r_n};
                        n_free = r_free + r_n;
                        n_carry = rdata;
                        if (cur_ok) begin
                            n_idx = idx_p1[CW-1:0];
                        end else begin
                            n_count = r_count + CW'(1);
                        end
                    end
                end else begin
                    n_prev_b = cur_b;
                    n_prev_l = cur_l;
                    n_idx    = idx_p1[CW-1:0];
                end
            end
            S_DROP: begin
                if (idx_p1 < {1'b0, r_count}) begin
                    we    = 1'b1;
                    wdata = rdata;
                    n_idx = idx_p1[CW-1:0];
                end else begin
                    n_count = r_count - CW'(1);
                end
            end
            S_INS: begin
                we      = 1'b1;
                wdata   = r_carry;
                n_carry = rdata;
                if (r_idx == r_count) begin
                    n_count = r_count + CW'(1);
                end else begin
                    n_idx = idx_p1[CW-1:0];
                end
            end
            S_DONE: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_free  <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_free  <= n_free;
            if (r_state == S_DONE && out_free) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_idx    <= n_idx;
        r_b      <= n_b;
        r_n      <= n_n;
        r_prev_b <= n_prev_b;
        r_prev_l <= n_prev_l;
        r_carry  <= n_carry;
        r_st     <= n_st;
        r_page   <= (n_st == ST_OK) ? n_page : '0;
        // load the result beat; hold it while stalled
        if (r_state == S_DONE && out_free) begin
            r_o_st   <= r_st;
            r_o_page <= r_page;
            r_o_free <= r_free;
        end
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_ov;
    assign o_status      = r_o_st;
    assign o_result_page = FIELD_BITS'(r_o_page);
    assign o_free_total  = FIELD_BITS'(r_o_free);

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_EXTENTS))
        else $error("extent count above table depth");

    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN || r_state == S_INS) |-> (r_idx <= r_count))
        else $error("walk index past entry count");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && out_free && r_st == ST_FULL) |-> table_full)
        else $error("full status with free table slots");

    a_page_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_st != ST_OK) |-> (r_page == '0))
        else $error("nonzero result page on failed item");
`endif

endmodule
